// ===== design/wrpd_pkg.sv =====
// Package for the wall range pose deviation block: types, widths and sine table builder.
package wrpd_pkg;

    // Field and datapath widths
    localparam int HALF_W      = 14;
    localparam int IN_DATA_W   = 96;
    localparam int OUT_DATA_W  = 40;
    localparam int DIV_NUM_W   = 34;
    localparam int DIV_DEN_W   = 17;
    localparam int SINE_DEPTH_DEF = 256;
    localparam logic [HALF_W-1:0] HALF_RESET = 14'd9216;

    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    // Controller states
    typedef enum logic [4:0] {
        ST_IDLE, ST_TAB, ST_ROT0, ST_ROT1, ST_ROT2, ST_ROT3, ST_ROT4,
        ST_W_OP, ST_W_GQ, ST_W_WP, ST_W_CMP, ST_W_BGP, ST_W_SEL, ST_POST,
        ST_DIV_T, ST_WAIT_T, ST_ERR_X, ST_ERR_Y, ST_ACC_Y, ST_FIN,
        ST_DIV_AX, ST_WAIT_AX, ST_DIV_AY, ST_WAIT_AY, ST_OUT
    } t_state;

    // Datapath operations
    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_TAB, OP_ROT0, OP_ROT1, OP_ROT2, OP_ROT3, OP_ROT4,
        OP_W_OP, OP_W_GQ, OP_W_WP, OP_W_CMP, OP_W_BGP, OP_W_SEL,
        OP_DIV_T, OP_ERR_X, OP_ERR_Y, OP_ACC_Y,
        OP_DIV_AX, OP_WAIT_AX, OP_DIV_AY, OP_WAIT_AY, OP_OUT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] wall;
    } t_dp_cmd;

    typedef struct packed {
        logic meas_neg;
        logic wall_ok;
        logic cross_in;
        logic has_hit;
        logic tally_full;
        logic tally_zero;
        logic last;
        logic div_done;
        logic out_full;
    } t_dp_status;

    // Q1.15 sine table entry k of a Depth-entry full-turn table
    function automatic logic signed [15:0] sine_entry(input int K, input int Depth);
        longint q;
        longint r;
        longint x;
        longint x2;
        longint t;
        longint v;
        longint e;
        q  = (4 * longint'(K)) / Depth;
        r  = 4 * longint'(K) - q * Depth;
        x  = r * HALF_PI_Q30 / Depth;
        x2 = (x * x) >>> 30;
        t  = Q30_ONE;
        if ((q & 1) == 0) begin
            t = Q30_ONE - ((x2 * t) >>> 30) / 110; if (t < 0) t = 0;
            t = Q30_ONE - ((x2 * t) >>> 30) / 72;  if (t < 0) t = 0;
            t = Q30_ONE - ((x2 * t) >>> 30) / 42;  if (t < 0) t = 0;
            t = Q30_ONE - ((x2 * t) >>> 30) / 20;  if (t < 0) t = 0;
            t = Q30_ONE - ((x2 * t) >>> 30) / 6;   if (t < 0) t = 0;
            v = (x * t) >>> 30;
        end else begin
            t = Q30_ONE - ((x2 * t) >>> 30) / 132; if (t < 0) t = 0;
            t = Q30_ONE - ((x2 * t) >>> 30) / 90;  if (t < 0) t = 0;
            t = Q30_ONE - ((x2 * t) >>> 30) / 56;  if (t < 0) t = 0;
            t = Q30_ONE - ((x2 * t) >>> 30) / 30;  if (t < 0) t = 0;
            t = Q30_ONE - ((x2 * t) >>> 30) / 12;  if (t < 0) t = 0;
            t = Q30_ONE - ((x2 * t) >>> 30) / 2;   if (t < 0) t = 0;
            v = t;
        end
        e = (v * 32767 + (Q30_ONE >>> 1)) >>> 30;
        if (e > 32767) e = 32767;
        if (q >= 2) e = -e;
        return 16'(e);
    endfunction

endpackage

// ===== design/wrpd_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned.
module wrpd_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [wrpd_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [wrpd_pkg::DIV_DEN_W-1:0] i_den,
    output logic [wrpd_pkg::DIV_NUM_W-1:0] o_quo,
    output logic                           o_done
);
    localparam int NW = wrpd_pkg::DIV_NUM_W;
    localparam int DW = wrpd_pkg::DIV_DEN_W;
    localparam int CW = $clog2(NW + 1);

    logic [DW:0]   r_rem;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DW:0]   rem_sh;
    logic [DW+1:0] diff;
    logic          ge;

    // One shift-subtract step
    always_comb begin
        rem_sh = {r_rem[DW-1:0], r_quo[NW-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_den};
        ge     = !diff[DW+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
                r_cnt  <= CW'(NW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? diff[DW:0] : rem_sh;
                r_quo <= {r_quo[NW-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;
endmodule

// ===== design/wrpd_datapath.sv =====
// Datapath: pose rotation, wall tests, range division, accumulation and averaging.
module wrpd_datapath #(
    parameter int SINE_TABLE_DEPTH = wrpd_pkg::SINE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  wrpd_pkg::t_dp_cmd               i_cmd,
    output wrpd_pkg::t_dp_status            o_sts,
    input  logic [wrpd_pkg::IN_DATA_W-1:0]  i_in_data,
    input  logic [1:0]                      i_facing,
    input  logic                            i_last,
    input  logic                            i_cfg_we,
    input  logic [wrpd_pkg::HALF_W-1:0]     i_cfg_wdata,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [wrpd_pkg::OUT_DATA_W-1:0] o_out_data
);
    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int IDXP_W = 16 + $clog2(SINE_TABLE_DEPTH + 1);
    localparam int NW     = wrpd_pkg::DIV_NUM_W;
    localparam int DW     = wrpd_pkg::DIV_DEN_W;

    // Sine table
    logic signed [15:0] w_tab [SINE_TABLE_DEPTH];
    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_tab
        assign w_tab[k] = wrpd_pkg::sine_entry(k, SINE_TABLE_DEPTH);
    end

    // Registers
    logic [wrpd_pkg::HALF_W-1:0] r_half;
    logic signed [15:0] r_px, r_py, r_ox, r_oy, r_meas;
    logic [15:0]        r_hd;
    logic [1:0]         r_face;
    logic               r_last;
    logic signed [15:0] r_s, r_c, r_dx, r_dy;
    logic signed [52:0] r_prod, r_acc;
    logic signed [18:0] r_sx, r_sy, r_best_g;
    logic signed [16:0] r_best_p;
    logic               r_hit;
    logic signed [31:0] r_sumx, r_sumy;
    logic [7:0]         r_tally;
    logic               r_avg_neg;
    logic signed [15:0] r_devx, r_devy;
    logic               r_out_valid;
    logic [wrpd_pkg::OUT_DATA_W-1:0] r_out_data;

    // Combinational signals
    logic [IDXP_W-1:0]  idx_s_full, idx_c_full;
    logic [15:0]        hd_c;
    logic signed [18:0] w_half, w_g, w_o;
    logic signed [16:0] w_p, w_q;
    logic signed [35:0] mul_a, nerr;
    logic signed [16:0] mul_b;
    logic signed [31:0] sel_sum;
    logic signed [34:0] avg_a, avg_mag;
    logic [DW-1:0]      avg_b;
    logic               div_start;
    logic [NW-1:0]      div_num, div_quo;
    logic [DW-1:0]      div_den;
    logic               div_done;
    logic signed [34:0] avg_res;
    logic signed [15:0] avg_sat;
    logic signed [52:0] prod_n;

    function automatic logic signed [52:0] round15(input logic signed [52:0] v);
        return (v + 53'sd16384) >>> 15;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [38:0] v);
        if (v > 39'sd2147483647)       return 32'sh7FFFFFFF;
        else if (v < -39'sd2147483648) return 32'sh80000000;
        else                           return 32'(v);
    endfunction

    // Table indexes for sin and cos
    always_comb begin
        hd_c       = r_hd + 16'd16384;
        idx_s_full = (IDXP_W'(r_hd) * IDXP_W'(SINE_TABLE_DEPTH)) >> 16;
        idx_c_full = (IDXP_W'(hd_c) * IDXP_W'(SINE_TABLE_DEPTH)) >> 16;
    end

    // Wall selection: gap, component toward wall, other coordinate, other component
    always_comb begin
        w_half = signed'({5'b0, r_half});
        unique case (i_cmd.wall)
            2'd0: begin
                w_g = w_half - r_sx; w_p = 17'(r_dx);    w_o = r_sy; w_q = 17'(r_dy);
            end
            2'd1: begin
                w_g = w_half + r_sx; w_p = -(17'(r_dx)); w_o = r_sy; w_q = 17'(r_dy);
            end
            2'd2: begin
                w_g = w_half - r_sy; w_p = 17'(r_dy);    w_o = r_sx; w_q = 17'(r_dx);
            end
            default: begin
                w_g = w_half + r_sy; w_p = -(17'(r_dy)); w_o = r_sx; w_q = 17'(r_dx);
            end
        endcase
    end

    // Shared multiplier operand select
    always_comb begin
        nerr = 36'(r_meas) - signed'({2'b00, div_quo});
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            wrpd_pkg::OP_ROT0:  begin mul_a = 36'(r_ox);     mul_b = 17'(r_c); end
            wrpd_pkg::OP_ROT1:  begin mul_a = 36'(r_oy);     mul_b = 17'(r_s); end
            wrpd_pkg::OP_ROT2:  begin mul_a = 36'(r_ox);     mul_b = 17'(r_s); end
            wrpd_pkg::OP_ROT3:  begin mul_a = 36'(r_oy);     mul_b = 17'(r_c); end
            wrpd_pkg::OP_W_OP:  begin mul_a = 36'(w_o);      mul_b = w_p; end
            wrpd_pkg::OP_W_GQ:  begin mul_a = 36'(w_g);      mul_b = w_q; end
            wrpd_pkg::OP_W_WP:  begin mul_a = 36'(w_half);   mul_b = w_p; end
            wrpd_pkg::OP_W_CMP: begin mul_a = 36'(w_g);      mul_b = r_best_p; end
            wrpd_pkg::OP_W_BGP: begin mul_a = 36'(r_best_g); mul_b = w_p; end
            wrpd_pkg::OP_ERR_X: begin mul_a = nerr;          mul_b = 17'(r_dx); end
            wrpd_pkg::OP_ERR_Y: begin mul_a = nerr;          mul_b = 17'(r_dy); end
            default: ;
        endcase
        prod_n = 53'(mul_a) * 53'(mul_b);
    end

    // Divider operands: wall range or rounded average
    always_comb begin
        sel_sum = (i_cmd.op == wrpd_pkg::OP_DIV_AY) ? r_sumy : r_sumx;
        avg_b   = {8'b0, r_tally, 1'b0};
        avg_a   = (35'(sel_sum) <<< 1) + signed'({27'b0, r_tally});
        avg_mag = avg_a[34] ? (-avg_a + signed'({18'b0, avg_b}) - 35'sd1) : avg_a;
        div_start = (i_cmd.op == wrpd_pkg::OP_DIV_T) || (i_cmd.op == wrpd_pkg::OP_DIV_AX)
                 || (i_cmd.op == wrpd_pkg::OP_DIV_AY);
        if (i_cmd.op == wrpd_pkg::OP_DIV_T) begin
            div_num = (NW'(r_best_g) << 16) + NW'(r_best_p);
            div_den = {r_best_p[DW-2:0], 1'b0};
        end else begin
            div_num = NW'(avg_mag);
            div_den = avg_b;
        end
        avg_res = r_avg_neg ? -signed'({1'b0, div_quo}) : signed'({1'b0, div_quo});
        if (avg_res > 35'sd32767)       avg_sat = 16'sh7FFF;
        else if (avg_res < -35'sd32768) avg_sat = 16'sh8000;
        else                            avg_sat = 16'(avg_res);
    end

    wrpd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quo   (div_quo),
        .o_done  (div_done)
    );

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= wrpd_pkg::HALF_RESET;
        end else if (i_cfg_we) begin
            r_half <= i_cfg_wdata;
        end
    end

    // Control-like state: hit flag, accumulators, tally, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit       <= 1'b0;
            r_sumx      <= '0;
            r_sumy      <= '0;
            r_tally     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            case (i_cmd.op)
                wrpd_pkg::OP_LOAD:  r_hit <= 1'b0;
                wrpd_pkg::OP_W_CMP: if ((r_acc <= r_prod) && (r_acc >= -r_prod)) r_hit <= 1'b1;
                wrpd_pkg::OP_ERR_Y: r_sumx <= sat32(39'(r_sumx) + 39'(round15(r_prod)));
                wrpd_pkg::OP_ACC_Y: begin
                    r_sumy  <= sat32(39'(r_sumy) + 39'(round15(r_prod)));
                    r_tally <= r_tally + 8'd1;
                end
                wrpd_pkg::OP_OUT: begin
                    r_sumx      <= '0;
                    r_sumy      <= '0;
                    r_tally     <= '0;
                    r_out_valid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_prod <= prod_n;
        case (i_cmd.op)
            wrpd_pkg::OP_LOAD: begin
                r_px   <= i_in_data[15:0];
                r_py   <= i_in_data[31:16];
                r_hd   <= i_in_data[47:32];
                r_ox   <= i_in_data[63:48];
                r_oy   <= i_in_data[79:64];
                r_meas <= i_in_data[95:80];
                r_face <= i_facing;
                r_last <= i_last;
            end
            wrpd_pkg::OP_TAB: begin
                r_s <= w_tab[idx_s_full[IDX_W-1:0]];
                r_c <= w_tab[idx_c_full[IDX_W-1:0]];
            end
            wrpd_pkg::OP_ROT0: begin
                unique case (r_face)
                    2'd0:    begin r_dx <= r_s;  r_dy <= r_c;  end
                    2'd1:    begin r_dx <= -r_s; r_dy <= -r_c; end
                    2'd2:    begin r_dx <= -r_c; r_dy <= r_s;  end
                    default: begin r_dx <= r_c;  r_dy <= -r_s; end
                endcase
            end
            wrpd_pkg::OP_ROT1: r_acc <= r_prod;
            wrpd_pkg::OP_ROT2: r_sx  <= 19'(r_px) + 19'(round15(r_acc - r_prod));
            wrpd_pkg::OP_ROT3: r_acc <= r_prod;
            wrpd_pkg::OP_ROT4: r_sy  <= 19'(r_py) + 19'(round15(r_acc + r_prod));
            wrpd_pkg::OP_W_GQ: r_acc <= r_prod;
            wrpd_pkg::OP_W_WP: r_acc <= r_acc + r_prod;
            wrpd_pkg::OP_W_CMP: begin
                if ((r_acc <= r_prod) && (r_acc >= -r_prod) && !r_hit) begin
                    r_best_g <= w_g;
                    r_best_p <= w_p;
                end
            end
            wrpd_pkg::OP_W_BGP: r_acc <= r_prod;
            wrpd_pkg::OP_W_SEL: begin
                if (r_acc < r_prod) begin
                    r_best_g <= w_g;
                    r_best_p <= w_p;
                end
            end
            wrpd_pkg::OP_DIV_AX, wrpd_pkg::OP_DIV_AY: r_avg_neg <= avg_a[34];
            wrpd_pkg::OP_WAIT_AX: if (div_done) r_devx <= avg_sat;
            wrpd_pkg::OP_WAIT_AY: if (div_done) r_devy <= avg_sat;
            wrpd_pkg::OP_OUT: begin
                if (r_tally == 8'd0) r_out_data <= '0;
                else                 r_out_data <= {r_tally, r_devy, r_devx};
            end
            default: ;
        endcase
    end

    // Status back to the controller
    always_comb begin
        o_sts.meas_neg   = r_meas[15];
        o_sts.wall_ok    = (w_g > 19'sd0) && (w_p > 17'sd0);
        o_sts.cross_in   = (r_acc <= r_prod) && (r_acc >= -r_prod);
        o_sts.has_hit    = r_hit;
        o_sts.tally_full = (r_tally == 8'd255);
        o_sts.tally_zero = (r_tally == 8'd0);
        o_sts.last       = r_last;
        o_sts.div_done   = div_done;
        o_sts.out_full   = r_out_valid;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
endmodule

// ===== design/wrpd_ctrl.sv =====
// Controller: sequences one reading through rotation, wall tests, division and averaging.
module wrpd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  wrpd_pkg::t_dp_status i_sts,
    output logic                 o_ready,
    output wrpd_pkg::t_dp_cmd    o_cmd
);
    wrpd_pkg::t_state r_state, n_state;
    logic [1:0]       r_wall, n_wall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wrpd_pkg::ST_IDLE;
            r_wall  <= '0;
        end else begin
            r_state <= n_state;
            r_wall  <= n_wall;
        end
    end

    // Next state and command
    always_comb begin
        n_state    = r_state;
        n_wall     = r_wall;
        o_ready    = 1'b0;
        o_cmd.op   = wrpd_pkg::OP_NONE;
        o_cmd.wall = r_wall;
        unique case (r_state)
            wrpd_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_accept) begin
                    o_cmd.op = wrpd_pkg::OP_LOAD;
                    n_state  = wrpd_pkg::ST_TAB;
                end
            end
            wrpd_pkg::ST_TAB: begin
                o_cmd.op = wrpd_pkg::OP_TAB;
                n_state  = i_sts.meas_neg ? wrpd_pkg::ST_FIN : wrpd_pkg::ST_ROT0;
            end
            wrpd_pkg::ST_ROT0: begin o_cmd.op = wrpd_pkg::OP_ROT0; n_state = wrpd_pkg::ST_ROT1; end
            wrpd_pkg::ST_ROT1: begin o_cmd.op = wrpd_pkg::OP_ROT1; n_state = wrpd_pkg::ST_ROT2; end
            wrpd_pkg::ST_ROT2: begin o_cmd.op = wrpd_pkg::OP_ROT2; n_state = wrpd_pkg::ST_ROT3; end
            wrpd_pkg::ST_ROT3: begin o_cmd.op = wrpd_pkg::OP_ROT3; n_state = wrpd_pkg::ST_ROT4; end
            wrpd_pkg::ST_ROT4: begin
                o_cmd.op = wrpd_pkg::OP_ROT4;
                n_wall   = 2'd0;
                n_state  = wrpd_pkg::ST_W_OP;
            end
            wrpd_pkg::ST_W_OP: begin
                o_cmd.op = wrpd_pkg::OP_W_OP;
                if (i_sts.wall_ok)       n_state = wrpd_pkg::ST_W_GQ;
                else if (r_wall == 2'd3) n_state = wrpd_pkg::ST_POST;
                else                     n_wall  = r_wall + 2'd1;
            end
            wrpd_pkg::ST_W_GQ: begin o_cmd.op = wrpd_pkg::OP_W_GQ; n_state = wrpd_pkg::ST_W_WP; end
            wrpd_pkg::ST_W_WP: begin o_cmd.op = wrpd_pkg::OP_W_WP; n_state = wrpd_pkg::ST_W_CMP; end
            wrpd_pkg::ST_W_CMP: begin
                o_cmd.op = wrpd_pkg::OP_W_CMP;
                if (i_sts.cross_in && i_sts.has_hit) begin
                    n_state = wrpd_pkg::ST_W_BGP;
                end else if (r_wall == 2'd3) begin
                    n_state = wrpd_pkg::ST_POST;
                end else begin
                    n_wall  = r_wall + 2'd1;
                    n_state = wrpd_pkg::ST_W_OP;
                end
            end
            wrpd_pkg::ST_W_BGP: begin o_cmd.op = wrpd_pkg::OP_W_BGP; n_state = wrpd_pkg::ST_W_SEL; end
            wrpd_pkg::ST_W_SEL: begin
                o_cmd.op = wrpd_pkg::OP_W_SEL;
                if (r_wall == 2'd3) begin
                    n_state = wrpd_pkg::ST_POST;
                end else begin
                    n_wall  = r_wall + 2'd1;
                    n_state = wrpd_pkg::ST_W_OP;
                end
            end
            wrpd_pkg::ST_POST: begin
                n_state = (i_sts.has_hit && !i_sts.tally_full) ? wrpd_pkg::ST_DIV_T
                                                               : wrpd_pkg::ST_FIN;
            end
            wrpd_pkg::ST_DIV_T: begin o_cmd.op = wrpd_pkg::OP_DIV_T; n_state = wrpd_pkg::ST_WAIT_T; end
            wrpd_pkg::ST_WAIT_T: if (i_sts.div_done) n_state = wrpd_pkg::ST_ERR_X;
            wrpd_pkg::ST_ERR_X: begin o_cmd.op = wrpd_pkg::OP_ERR_X; n_state = wrpd_pkg::ST_ERR_Y; end
            wrpd_pkg::ST_ERR_Y: begin o_cmd.op = wrpd_pkg::OP_ERR_Y; n_state = wrpd_pkg::ST_ACC_Y; end
            wrpd_pkg::ST_ACC_Y: begin o_cmd.op = wrpd_pkg::OP_ACC_Y; n_state = wrpd_pkg::ST_FIN; end
            wrpd_pkg::ST_FIN: begin
                if (!i_sts.last)          n_state = wrpd_pkg::ST_IDLE;
                else if (i_sts.tally_zero) n_state = wrpd_pkg::ST_OUT;
                else                      n_state = wrpd_pkg::ST_DIV_AX;
            end
            wrpd_pkg::ST_DIV_AX: begin o_cmd.op = wrpd_pkg::OP_DIV_AX; n_state = wrpd_pkg::ST_WAIT_AX; end
            wrpd_pkg::ST_WAIT_AX: begin
                o_cmd.op = wrpd_pkg::OP_WAIT_AX;
                if (i_sts.div_done) n_state = wrpd_pkg::ST_DIV_AY;
            end
            wrpd_pkg::ST_DIV_AY: begin o_cmd.op = wrpd_pkg::OP_DIV_AY; n_state = wrpd_pkg::ST_WAIT_AY; end
            wrpd_pkg::ST_WAIT_AY: begin
                o_cmd.op = wrpd_pkg::OP_WAIT_AY;
                if (i_sts.div_done) n_state = wrpd_pkg::ST_OUT;
            end
            wrpd_pkg::ST_OUT: begin
                if (!i_sts.out_full) begin
                    o_cmd.op = wrpd_pkg::OP_OUT;
                    n_state  = wrpd_pkg::ST_IDLE;
                end
            end
            default: n_state = wrpd_pkg::ST_IDLE;
        endcase
    end
endmodule

// ===== design/wall_range_pose_deviation_top.sv =====
// Top level of the wall range pose deviation block.
// Channel   Dir  Handshake            Payload
// s (in)    in   i_s_tvalid/o_s_tready  tdata 96b, tuser facing, tlast last_reading
// m (out)   out  o_m_tvalid/i_m_tready  tdata 40b: deviation_x, deviation_y, used_count
// cfg       in   i_cfg_we               i_cfg_wdata field_half_size
// One reading at a time: an invalid range skips the rotation and wall tests, no wall hit or a
// full tally skips the division, and with a hit the 34-step division dominates.
// A last reading adds two 34-step average divisions before the result,
// which an empty group skips.
// Reset is synchronous; the result sits in an output register, so the block takes
// the next reading while it waits and stalls only when a new result finds it still full.
module wall_range_pose_deviation_top #(
    parameter int SINE_TABLE_DEPTH = wrpd_pkg::SINE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // pos_x, pos_y, heading, offset_x, offset_y, measured_range
    input  logic [wrpd_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // facing
    input  logic [1:0]                      i_s_tuser,
    input  logic                            i_s_tlast,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // deviation_x, deviation_y, used_count
    output logic [wrpd_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input  logic                            i_cfg_we,
    input  logic [wrpd_pkg::HALF_W-1:0]     i_cfg_wdata
);
    wrpd_pkg::t_dp_cmd    cmd;
    wrpd_pkg::t_dp_status sts;
    logic                 ready;

    assign o_s_tready = ready;

    wrpd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (i_s_tvalid && ready),
        .i_sts    (sts),
        .o_ready  (ready),
        .o_cmd    (cmd)
    );

    wrpd_datapath #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_s_tdata),
        .i_facing    (i_s_tuser),
        .i_last      (i_s_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_data  (o_m_tdata)
    );
endmodule

// ===== design/wrpd_checker.sv =====
// Port-level checker for the wall range pose deviation block, with its bind.
module wrpd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [wrpd_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    // Result held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result dropped or changed under stall");

    // Empty group gives zero deviations
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[39:32] == 8'd0) |-> (o_m_tdata[31:0] == 32'd0))
        else $error("nonzero deviation with zero count");

    // One reading at a time: no transfer right after a transfer
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken while busy");

    // No result appears while the block was idle and ready for input
    a_no_result_unasked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid ##1 o_m_tvalid |-> $past(!o_s_tready))
        else $error("result appeared while idle");

    // Reset empties the output register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");
endmodule

bind wall_range_pose_deviation_top wrpd_checker u_wrpd_checker (.*);
